// File: sv/glyph_column_text_renderer_defines.svh
// ----------------------------------------------------------------------------
// Glyph column text renderer - assertion macros
// Concurrent assertion wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GLYPH_COLUMN_TEXT_RENDERER_DEFINES_SVH
`define GLYPH_COLUMN_TEXT_RENDERER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define GCTR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gctr: same-cycle check failed");
// next-cycle implication
`define GCTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gctr: next-cycle check failed");
`else
`define GCTR_ASSERT_IMPLY(label, ante, cons)
`define GCTR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/gctr_pkg.sv
// ----------------------------------------------------------------------------
// gctr_pkg - shared types and constants
// Screen geometry, glyph store layout, byte codes, beat structs, FSM encoding.
// ----------------------------------------------------------------------------
package gctr_pkg;

    // geometry
    localparam int SCREEN_COLUMNS = 84;
    localparam int ROW_BANKS      = 6;
    localparam int GLYPH_COLUMNS  = 5;
    localparam int GLYPH_COUNT    = 96;
    localparam int STORE_DEPTH    = GLYPH_COUNT * GLYPH_COLUMNS;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);
    localparam int COL_W          = 7;
    localparam int ROW_W          = 3;
    localparam int IDX_W          = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
    localparam int WIDTH_W        = $clog2(GLYPH_COLUMNS + 1);

    // byte codes
    localparam logic [7:0] SKIP_MARK    = 8'h80;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] FIRST_CODE   = 8'd32;
    localparam logic [7:0] LAST_CODE    = 8'd127;
    localparam logic [7:0] SET_COL_CMD  = 8'h80;
    localparam logic [7:0] SET_ROW_CMD  = 8'h40;

    // input operation codes
    localparam logic [1:0] OP_DRAW   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [8:0] glyph_address;
        logic [7:0] glyph_byte;
        logic [6:0] target_column;
        logic [2:0] target_row;
    } t_in_beat;

    typedef struct packed {
        logic       is_command;
        logic [7:0] out_byte;
        logic       last;
    } t_out_beat;

    // decoded input item
    typedef enum logic [2:0] {
        K_NONE,
        K_NEWLINE,
        K_GLYPH,
        K_LOAD,
        K_CURSOR
    } t_item_kind;

    // what the output register is loaded with
    typedef enum logic [2:0] {
        EM_NONE,
        EM_SETCOL,
        EM_SETROW,
        EM_DATA,
        EM_SPACE
    } t_emit;

    // source of the pending cursor jump
    typedef enum logic [1:0] {
        GO_HOLD,
        GO_TARGET,
        GO_WRAP
    } t_go_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_FIT,
        S_FCOL,
        S_FROW,
        S_GCOL,
        S_GROW,
        S_DATA,
        S_SPACE
    } t_state;

    typedef struct packed {
        t_go_sel go_sel;
        logic    base_ld;
        logic    mem_wr;
        logic    rd_en;
        logic    idx_clr;
        logic    idx_inc;
        t_emit   emit;
        logic    last;
    } t_dp_cmd;

    typedef struct packed {
        t_item_kind kind;
        logic       out_free;
        logic       idx_last;
        logic       col_skip;
        logic       fit_wrap;
    } t_dp_stat;

endpackage

// File: sv/gctr_ctrl.sv
// ----------------------------------------------------------------------------
// gctr_ctrl - sequencing FSM
// Takes the item kind decoded by the datapath and steps it through glyph scan,
// fit check, cursor commands, column beats and the trailing spacer.
// ----------------------------------------------------------------------------
module gctr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  gctr_pkg::t_dp_stat i_stat,
    output gctr_pkg::t_dp_cmd  o_cmd,
    output logic               o_in_stall
);

    gctr_pkg::t_state r_state;
    gctr_pkg::t_state n_state;

    // only take a new item once the previous one is fully sequenced
    assign o_in_stall = (r_state != gctr_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gctr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gctr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_stat.kind)
                        gctr_pkg::K_NEWLINE: n_state = gctr_pkg::S_GCOL;
                        gctr_pkg::K_CURSOR:  n_state = gctr_pkg::S_GCOL;
                        gctr_pkg::K_GLYPH:   n_state = gctr_pkg::S_SCAN;
                        default:             n_state = gctr_pkg::S_IDLE;
                    endcase
                end
            end
            gctr_pkg::S_SCAN: begin
                if (i_stat.idx_last) n_state = gctr_pkg::S_FIT;
            end
            gctr_pkg::S_FIT: begin
                n_state = i_stat.fit_wrap ? gctr_pkg::S_FCOL : gctr_pkg::S_DATA;
            end
            gctr_pkg::S_FCOL: begin
                if (i_stat.out_free) n_state = gctr_pkg::S_FROW;
            end
            gctr_pkg::S_FROW: begin
                if (i_stat.out_free) n_state = gctr_pkg::S_DATA;
            end
            gctr_pkg::S_GCOL: begin
                if (i_stat.out_free) n_state = gctr_pkg::S_GROW;
            end
            gctr_pkg::S_GROW: begin
                if (i_stat.out_free) n_state = gctr_pkg::S_IDLE;
            end
            gctr_pkg::S_DATA: begin
                if ((i_stat.col_skip || i_stat.out_free) && i_stat.idx_last) begin
                    n_state = gctr_pkg::S_SPACE;
                end
            end
            gctr_pkg::S_SPACE: begin
                if (i_stat.out_free) n_state = gctr_pkg::S_IDLE;
            end
            default: n_state = gctr_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.go_sel  = gctr_pkg::GO_HOLD;
        o_cmd.emit    = gctr_pkg::EM_NONE;
        unique case (r_state)
            gctr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_stat.kind)
                        gctr_pkg::K_NEWLINE: o_cmd.go_sel = gctr_pkg::GO_WRAP;
                        gctr_pkg::K_CURSOR:  o_cmd.go_sel = gctr_pkg::GO_TARGET;
                        gctr_pkg::K_GLYPH: begin
                            o_cmd.base_ld = 1'b1;
                            o_cmd.idx_clr = 1'b1;
                        end
                        gctr_pkg::K_LOAD:    o_cmd.mem_wr = 1'b1;
                        default:             o_cmd.mem_wr = 1'b0;
                    endcase
                end
            end
            gctr_pkg::S_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            gctr_pkg::S_FIT: begin
                o_cmd.idx_clr = 1'b1;
                if (i_stat.fit_wrap) o_cmd.go_sel = gctr_pkg::GO_WRAP;
            end
            gctr_pkg::S_FCOL, gctr_pkg::S_GCOL: begin
                if (i_stat.out_free) o_cmd.emit = gctr_pkg::EM_SETCOL;
            end
            gctr_pkg::S_FROW: begin
                if (i_stat.out_free) o_cmd.emit = gctr_pkg::EM_SETROW;
            end
            gctr_pkg::S_GROW: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = gctr_pkg::EM_SETROW;
                    o_cmd.last = 1'b1;
                end
            end
            gctr_pkg::S_DATA: begin
                // skipped columns advance the column index but emit no beat
                if (i_stat.col_skip) begin
                    o_cmd.idx_inc = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.idx_inc = 1'b1;
                    o_cmd.emit    = gctr_pkg::EM_DATA;
                end
            end
            gctr_pkg::S_SPACE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = gctr_pkg::EM_SPACE;
                    o_cmd.last = 1'b1;
                end
            end
            default: o_cmd.last = 1'b0;
        endcase
    end

endmodule

// File: sv/gctr_dp.sv
// ----------------------------------------------------------------------------
// gctr_dp - renderer datapath
// Glyph store, column buffer, cursor, pending jump target and the output
// register. Decodes the incoming item for the controller.
// ----------------------------------------------------------------------------
module gctr_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gctr_pkg::t_in_beat  i_in,
    input  logic                i_out_stall,
    input  gctr_pkg::t_dp_cmd   i_cmd,
    output gctr_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    output gctr_pkg::t_out_beat o_out
);

    localparam int COL_W = gctr_pkg::COL_W;
    localparam int ROW_W = gctr_pkg::ROW_W;
    localparam int AW    = gctr_pkg::STORE_AW;

    logic [7:0]         r_mem  [gctr_pkg::STORE_DEPTH];
    logic [7:0]         r_cols [gctr_pkg::GLYPH_COLUMNS];
    logic [AW-1:0]      r_base;
    logic [gctr_pkg::IDX_W-1:0] r_idx;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_go_col;
    logic [ROW_W-1:0]   r_go_row;
    logic               r_out_valid;
    gctr_pkg::t_out_beat r_out;

    logic [7:0]         w_glyph_off;
    logic [AW-1:0]      w_base;
    logic [AW-1:0]      w_rd_addr;
    logic               w_printable;
    gctr_pkg::t_item_kind w_kind;
    logic [gctr_pkg::WIDTH_W-1:0] w_width;
    logic [COL_W-1:0]   w_room;
    logic [COL_W:0]     w_col_inc;
    logic               w_out_free;

    // wrap a row bank index
    function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] row);
        logic [ROW_W:0] r;
        r = {1'b0, row} + 1'b1;
        return (r >= (ROW_W+1)'(gctr_pkg::ROW_BANKS)) ? '0 : r[ROW_W-1:0];
    endfunction

    // item decode
    assign w_glyph_off = i_in.char_code - gctr_pkg::FIRST_CODE;
    assign w_printable = (i_in.char_code >= gctr_pkg::FIRST_CODE)
                      && (i_in.char_code <= gctr_pkg::LAST_CODE)
                      && (32'(w_glyph_off) < gctr_pkg::GLYPH_COUNT);
    assign w_base      = AW'(32'(w_glyph_off) * gctr_pkg::GLYPH_COLUMNS);

    always_comb begin
        w_kind = gctr_pkg::K_NONE;
        unique case (i_in.command)
            gctr_pkg::OP_DRAW: begin
                if (i_in.char_code == gctr_pkg::NEWLINE_CODE) begin
                    w_kind = gctr_pkg::K_NEWLINE;
                end else if (w_printable) begin
                    w_kind = gctr_pkg::K_GLYPH;
                end
            end
            gctr_pkg::OP_LOAD: begin
                if (32'(i_in.glyph_address) < gctr_pkg::STORE_DEPTH) begin
                    w_kind = gctr_pkg::K_LOAD;
                end
            end
            gctr_pkg::OP_CURSOR: w_kind = gctr_pkg::K_CURSOR;
            default:             w_kind = gctr_pkg::K_NONE;
        endcase
    end

    // glyph store: load port, registered read into the column buffer
    assign w_rd_addr = r_base + AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[AW'(i_in.glyph_address)] <= i_in.glyph_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_cols[r_idx] <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_ld) begin
            r_base <= w_base;
        end
    end

    // column counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // drawn width against room left on the row
    always_comb begin
        w_width = '0;
        for (int j = 0; j < gctr_pkg::GLYPH_COLUMNS; j++) begin
            if (r_cols[j] != gctr_pkg::SKIP_MARK) w_width = w_width + 1'b1;
        end
    end

    assign w_room = (r_col >= COL_W'(gctr_pkg::SCREEN_COLUMNS)) ? '0
                  : COL_W'(gctr_pkg::SCREEN_COLUMNS) - r_col;

    // pending jump target
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.go_sel)
            gctr_pkg::GO_TARGET: begin
                r_go_col <= i_in.target_column;
                r_go_row <= i_in.target_row;
            end
            gctr_pkg::GO_WRAP: begin
                r_go_col <= '0;
                r_go_row <= next_row(r_row);
            end
            default: begin
                r_go_col <= r_go_col;
                r_go_row <= r_go_row;
            end
        endcase
    end

    // cursor
    assign w_col_inc = {1'b0, r_col} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            unique case (i_cmd.emit)
                gctr_pkg::EM_SETCOL: r_col <= r_go_col;
                gctr_pkg::EM_SETROW: r_row <= r_go_row;
                gctr_pkg::EM_DATA, gctr_pkg::EM_SPACE: begin
                    if (w_col_inc >= (COL_W+1)'(gctr_pkg::SCREEN_COLUMNS)) begin
                        r_col <= '0;
                        r_row <= next_row(r_row);
                    end else begin
                        r_col <= w_col_inc[COL_W-1:0];
                    end
                end
                default: r_col <= r_col;
            endcase
        end
    end

    // output register
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != gctr_pkg::EM_NONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != gctr_pkg::EM_NONE) begin
            r_out.last <= i_cmd.last;
        end
        unique case (i_cmd.emit)
            gctr_pkg::EM_SETCOL: begin
                r_out.is_command <= 1'b1;
                r_out.out_byte   <= gctr_pkg::SET_COL_CMD | 8'(r_go_col);
            end
            gctr_pkg::EM_SETROW: begin
                r_out.is_command <= 1'b1;
                r_out.out_byte   <= gctr_pkg::SET_ROW_CMD | 8'(r_go_row);
            end
            gctr_pkg::EM_DATA: begin
                r_out.is_command <= 1'b0;
                r_out.out_byte   <= r_cols[r_idx];
            end
            gctr_pkg::EM_SPACE: begin
                r_out.is_command <= 1'b0;
                r_out.out_byte   <= 8'h00;
            end
            default: begin
                r_out.is_command <= r_out.is_command;
                r_out.out_byte   <= r_out.out_byte;
            end
        endcase
    end

    // status
    assign o_stat = '{
        kind:     w_kind,
        out_free: w_out_free,
        idx_last: (r_idx == gctr_pkg::IDX_W'(gctr_pkg::GLYPH_COLUMNS - 1)),
        col_skip: (r_cols[r_idx] == gctr_pkg::SKIP_MARK),
        fit_wrap: (COL_W'(w_width) > w_room)
    };

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: sv/glyph_column_text_renderer.sv
// ----------------------------------------------------------------------------
// glyph_column_text_renderer - bitmap font text renderer for a banked LCD
// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall   gctr_pkg::t_in_beat
// out       source     o_out_valid / i_out_stall gctr_pkg::t_out_beat
//
// Glyph load and ignored items finish on acceptance; newline and set cursor
// send two command beats (set column, set row). A character's columns are
// scanned through the single read port of the glyph store into the column
// buffer, then replayed as data beats and a spacer, after a wrap if needed.
// Reset is synchronous, active low; cursor goes to column 0, row 0; the glyph
// store is not cleared. Output stalls hold the sequencer beat for beat.
// ----------------------------------------------------------------------------
`include "glyph_column_text_renderer_defines.svh"

module glyph_column_text_renderer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gctr_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gctr_pkg::t_out_beat o_out
);

    gctr_pkg::t_dp_cmd  w_cmd;
    gctr_pkg::t_dp_stat w_stat;
    logic               w_in_take;
    logic               w_beat_load;

    // sequencer
    gctr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // store, cursor and output register
    gctr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    assign w_in_take   = i_in_valid && !o_in_stall;
    assign w_beat_load = (w_cmd.emit != gctr_pkg::EM_NONE);

    // a beat is only loaded into a free output register
    `GCTR_ASSERT_IMPLY(a_emit_into_free, w_beat_load, w_stat.out_free)

    // the final beat of an item returns the sequencer to idle
    `GCTR_ASSERT_NEXT(a_last_ends_item, w_beat_load && w_cmd.last, !o_in_stall)

    // a glyph item holds off the next item while it is drawn
    `GCTR_ASSERT_NEXT(a_glyph_busy, w_in_take && (w_stat.kind == gctr_pkg::K_GLYPH), o_in_stall)

endmodule
